>>> rtl/core/lekb_pkg.sv
// ---------------------------------------------------------------------------
// lekb_pkg
// Shared constants and controller/datapath interface types for the line
// editor with erase and kill characters.
// ---------------------------------------------------------------------------
package lekb_pkg;

  localparam int LINE_DEPTH = 63;
  localparam int FILL_W     = $clog2(LINE_DEPTH + 1);
  localparam int IDX_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int CHAR_W     = 8;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE   = 8'd10;
  localparam logic [CHAR_W-1:0] ERASE_RST      = 8'd35;
  localparam logic [CHAR_W-1:0] KILL_RST       = 8'd64;

  // Register select, taken from the word address bit of paddr.
  localparam logic REG_ERASE = 1'b0;
  localparam logic REG_KILL  = 1'b1;

  typedef struct packed {
    logic edit;  // apply the accepted character to the buffer
    logic emit;  // load the next result into the output register
  } lekb_cmd_t;

  typedef struct packed {
    logic              is_newline;
    logic              drain_done;
    logic              out_free;
    logic [FILL_W-1:0] fill_count;
  } lekb_sts_t;

endpackage

>>> rtl/core/line_edit_erase_kill_buffer.sv
// ---------------------------------------------------------------------------
// line_edit_erase_kill_buffer
// Line editor with erase and kill characters over a 63-entry line buffer.
//
// Characters arrive on the in_ channel (valid/ready), one item per cycle.
// Ordinary characters are buffered, the erase character drops the last one,
// the kill character clears the line; none of these produce a result.
// A newline item starts a drain: the buffered characters come out on the
// out_ channel oldest first, one item per cycle from the memory read port,
// followed by a newline with out_last set and out_overflowed reporting any
// characters dropped because the buffer was full. After the newline is
// accepted the controller enters its drain state, and the first result is
// then loaded into the output register. in_ready stays low during the drain.
// When the receiver stalls, the output register holds its item and the
// drain pauses. Input items are taken while the final newline still waits.
// erase_char and kill_char are written through the APB port at byte
// addresses 0 and 4. Synchronous reset empties the line, clears the drop
// flag and output valid, and restores the register defaults.
// ---------------------------------------------------------------------------
module line_edit_erase_kill_buffer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lekb_pkg::CHAR_W-1:0]   in_char,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lekb_pkg::CHAR_W-1:0]   out_char,
  output logic                          out_last,
  output logic                          out_overflowed,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lekb_pkg::APB_AW-1:0]   paddr,
  input  logic [lekb_pkg::APB_DW-1:0]   pwdata,
  output logic [lekb_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import lekb_pkg::*;

  logic [CHAR_W-1:0] erase_r;
  logic [CHAR_W-1:0] kill_r;
  logic              reg_wr;
  logic              reg_sel;
  lekb_cmd_t         cmd;
  lekb_sts_t         sts;

  assign pready  = 1'b1;
  assign reg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      erase_r <= ERASE_RST;
      kill_r  <= KILL_RST;
    end else if (reg_wr) begin
      unique case (reg_sel)
        REG_ERASE: erase_r <= pwdata[CHAR_W-1:0];
        REG_KILL:  kill_r  <= pwdata[CHAR_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_ERASE: prdata = APB_DW'(erase_r);
      REG_KILL:  prdata = APB_DW'(kill_r);
      default:   prdata = '0;
    endcase
  end

  lekb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lekb_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_char        (in_char),
    .erase_char     (erase_r),
    .kill_char      (kill_r),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char       (out_char),
    .out_last       (out_last),
    .out_overflowed (out_overflowed)
  );

`ifndef SYNTHESIS
  a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    sts.fill_count <= FILL_W'(LINE_DEPTH))
    else $error("line buffer fill count exceeds its depth");

  a_close_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && sts.drain_done) |=> (sts.fill_count == '0))
    else $error("closing newline did not empty the line buffer");

  a_newline_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_char == NEWLINE_CODE) |=> (!in_ready && !cmd.edit))
    else $error("input taken right after an accepted newline");
`endif

endmodule

>>> rtl/core/lekb_dp.sv
// ---------------------------------------------------------------------------
// lekb_dp
// Line buffer datapath: character memory, fill count, drop flag, drain
// index and the registered output stage.
// ---------------------------------------------------------------------------
module lekb_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lekb_pkg::lekb_cmd_t            cmd,
  output lekb_pkg::lekb_sts_t            sts,
  input  logic [lekb_pkg::CHAR_W-1:0]    in_char,
  input  logic [lekb_pkg::CHAR_W-1:0]    erase_char,
  input  logic [lekb_pkg::CHAR_W-1:0]    kill_char,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [lekb_pkg::CHAR_W-1:0]    out_char,
  output logic                           out_last,
  output logic                           out_overflowed
);
  import lekb_pkg::*;

  logic [CHAR_W-1:0] mem [0:LINE_DEPTH-1];

  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              drop_r, drop_nxt;
  logic [FILL_W-1:0] rd_idx_r, rd_idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r;
  logic              out_last_r;
  logic              out_ovf_r;
  logic              push;
  logic              drain_done;

  assign drain_done = (rd_idx_r == fill_r);
  assign push = cmd.edit && (in_char != erase_char) && (in_char != kill_char) &&
                (fill_r < FILL_W'(LINE_DEPTH));

  always_comb begin
    fill_nxt   = fill_r;
    drop_nxt   = drop_r;
    rd_idx_nxt = rd_idx_r;
    if (cmd.edit) begin
      // Erase wins over kill when both registers hold the same code.
      if (in_char == erase_char) begin
        if (fill_r != '0) begin
          fill_nxt = fill_r - FILL_W'(1);
        end
      end else if (in_char == kill_char) begin
        fill_nxt = '0;
        drop_nxt = 1'b0;
      end else if (push) begin
        fill_nxt = fill_r + FILL_W'(1);
      end else begin
        drop_nxt = 1'b1;
      end
    end
    if (cmd.emit) begin
      if (drain_done) begin
        fill_nxt   = '0;
        drop_nxt   = 1'b0;
        rd_idx_nxt = '0;
      end else begin
        rd_idx_nxt = rd_idx_r + FILL_W'(1);
      end
    end
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      drop_r      <= 1'b0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      drop_r      <= drop_nxt;
      rd_idx_r    <= rd_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[fill_r[IDX_W-1:0]] <= in_char;
    end
  end

  // The output register doubles as the registered read port of the memory.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (drain_done) begin
        out_char_r <= NEWLINE_CODE;
        out_last_r <= 1'b1;
        out_ovf_r  <= drop_r;
      end else begin
        out_char_r <= mem[rd_idx_r[IDX_W-1:0]];
        out_last_r <= 1'b0;
        out_ovf_r  <= 1'b0;
      end
    end
  end

  assign sts.is_newline = (in_char == NEWLINE_CODE);
  assign sts.drain_done = drain_done;
  assign sts.out_free   = !out_valid_r || out_ready;
  assign sts.fill_count = fill_r;

  assign out_valid      = out_valid_r;
  assign out_char       = out_char_r;
  assign out_last       = out_last_r;
  assign out_overflowed = out_ovf_r;

endmodule

>>> rtl/core/lekb_ctrl.sv
// ---------------------------------------------------------------------------
// lekb_ctrl
// Controller: accepts characters while idle and sequences the drain of the
// line buffer after a newline.
// ---------------------------------------------------------------------------
module lekb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lekb_pkg::lekb_sts_t sts,
  output lekb_pkg::lekb_cmd_t cmd
);
  import lekb_pkg::*;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic state_r, state_nxt;
  logic accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd.edit  = 1'b0;
    cmd.emit  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (sts.is_newline) begin
            state_nxt = ST_DRAIN;
          end else begin
            cmd.edit = 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        // One result per cycle whenever the output register has room.
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.drain_done) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
